### rtl/usb_cee_pkg.sv
// Package for the USB control endpoint zero engine.
// Holds event, request, action and device-state codes and the transfer structs.
// No dependencies.
`default_nettype none

package usb_cee_pkg;

  typedef logic [2:0] event_code_t;
  localparam event_code_t EV_BUS_RESET = 3'd0;
  localparam event_code_t EV_MODULE_ON = 3'd1;
  localparam event_code_t EV_SETUP     = 3'd2;
  localparam event_code_t EV_IN        = 3'd3;
  localparam event_code_t EV_ACK       = 3'd4;
  localparam event_code_t EV_OTHER     = 3'd5;

  typedef logic [7:0] req_code_t;
  localparam req_code_t RQ_SET_ADDRESS    = 8'd5;
  localparam req_code_t RQ_GET_DESCRIPTOR = 8'd6;
  localparam req_code_t RQ_SET_CONFIG     = 8'd9;
  localparam req_code_t RQ_GET_INTERFACE  = 8'd10;

  typedef logic [1:0] action_t;
  localparam action_t ACT_NONE  = 2'd0;
  localparam action_t ACT_ARM   = 2'd1;
  localparam action_t ACT_STALL = 2'd2;

  typedef logic [1:0] dev_state_t;
  localparam dev_state_t DS_POWERED    = 2'd0;
  localparam dev_state_t DS_DEFAULT    = 2'd1;
  localparam dev_state_t DS_ADDRESSED  = 2'd2;
  localparam dev_state_t DS_CONFIGURED = 2'd3;

  localparam logic SRC_DESCRIPTOR = 1'b0;
  localparam logic SRC_CONST_ONE  = 1'b1;

  localparam logic [6:0] CFG_PACKET_RESET = 7'd8;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  endpoint;
    logic [7:0]  request_type_bits;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic        descriptor_found;
    logic [15:0] descriptor_length;
  } request_t;

  typedef struct packed {
    logic [1:0]  packet_action;
    logic        payload_source;
    logic [15:0] payload_offset;
    logic [6:0]  payload_count;
    logic        data_toggle;
    logic [1:0]  device_state;
    logic [6:0]  device_address;
    logic        ep1_in_enabled;
  } result_t;

  typedef struct packed {
    logic     valid;
    request_t req;
  } staged_req_t;

endpackage

`default_nettype wire

### rtl/usb_cee_ifs.sv
// Channel interfaces of the USB control endpoint zero engine:
// request, result and configuration write channels.
// No dependencies.
`default_nettype none

interface usb_cee_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  endpoint;
  logic [7:0]  request_type_bits;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_length;
  logic        descriptor_found;
  logic [15:0] descriptor_length;

  modport source (
    output valid, req_type, endpoint, request_type_bits, request_code,
           request_value, request_length, descriptor_found, descriptor_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, endpoint, request_type_bits, request_code,
           request_value, request_length, descriptor_found, descriptor_length,
    output ready
  );
endinterface

interface usb_cee_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_action;
  logic        payload_source;
  logic [15:0] payload_offset;
  logic [6:0]  payload_count;
  logic        data_toggle;
  logic [1:0]  device_state;
  logic [6:0]  device_address;
  logic        ep1_in_enabled;

  modport source (
    output valid, packet_action, payload_source, payload_offset, payload_count,
           data_toggle, device_state, device_address, ep1_in_enabled,
    input  ready
  );
  modport sink (
    input  valid, packet_action, payload_source, payload_offset, payload_count,
           data_toggle, device_state, device_address, ep1_in_enabled,
    output ready
  );
endinterface

interface usb_cee_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] max_packet_bytes;

  modport source (output valid, max_packet_bytes, input ready);
  modport sink (input valid, max_packet_bytes, output ready);
endinterface

`default_nettype wire

### rtl/usb_cee_in_reg.sv
// Input register of the USB control endpoint zero engine.
// Depends on usb_cee_pkg.
`default_nettype none

module usb_cee_in_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire usb_cee_pkg::request_t in_req,
  input  wire logic                  advance,
  output usb_cee_pkg::staged_req_t   staged
);
  import usb_cee_pkg::*;

  logic     valid;
  request_t req;

  assign in_ready = !valid || advance;
  assign staged   = '{valid: valid, req: req};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_req;
    end
  end

endmodule

`default_nettype wire

### rtl/usb_cee_core.sv
// Protocol core of the USB control endpoint zero engine: device state,
// address handling, delivery tracking and packet-size register.
// Depends on usb_cee_pkg.
`default_nettype none

module usb_cee_core #(
  parameter int PACKET_BYTES_MAX = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [6:0]            cfg_data,
  input  wire logic                  take,
  input  wire usb_cee_pkg::request_t req,
  output usb_cee_pkg::result_t       result
);
  import usb_cee_pkg::*;

  localparam logic [6:0] PKT_MAX = 7'(PACKET_BYTES_MAX);

  logic [6:0]  max_packet_bytes;
  dev_state_t  dev_state, dev_state_next;
  logic [6:0]  active_address, active_address_next;
  logic [6:0]  pending_address, pending_address_next;
  logic        address_pending, address_pending_next;
  logic        sending, sending_next;
  logic [15:0] bytes_sent, bytes_sent_next;
  logic [15:0] send_end, send_end_next;
  logic        data_pid, data_pid_next;
  logic        source_sel, source_sel_next;
  logic        ep1_on, ep1_on_next;

  logic [6:0]  size;
  logic        start, emit;
  logic        start_src;
  logic [15:0] start_total, start_limit;
  logic        cur_src, cur_toggle;
  logic [15:0] cur_sent, cur_end, remain;
  logic [6:0]  count;

  always_comb begin
    if (max_packet_bytes == 7'd0) begin
      size = 7'd1;
    end else if (max_packet_bytes > PKT_MAX) begin
      size = PKT_MAX;
    end else begin
      size = max_packet_bytes;
    end
  end

  always_comb begin
    dev_state_next       = dev_state;
    active_address_next  = active_address;
    pending_address_next = pending_address;
    address_pending_next = address_pending;
    sending_next         = sending;
    bytes_sent_next      = bytes_sent;
    send_end_next        = send_end;
    data_pid_next        = data_pid;
    source_sel_next      = source_sel;
    ep1_on_next          = ep1_on;
    start                = 1'b0;
    emit                 = 1'b0;
    start_src            = SRC_DESCRIPTOR;
    start_total          = 16'd0;
    start_limit          = 16'd0;
    result               = '0;
    result.packet_action = ACT_NONE;

    unique case (req.req_type)
      EV_BUS_RESET: begin
        sending_next         = 1'b0;
        active_address_next  = 7'd0;
        pending_address_next = 7'd0;
        address_pending_next = 1'b0;
        dev_state_next       = DS_DEFAULT;
        ep1_on_next          = 1'b0;
      end
      EV_MODULE_ON: begin
        dev_state_next = DS_DEFAULT;
      end
      EV_SETUP: begin
        if (req.endpoint == 4'd0) begin
          if (req.request_type_bits[6:5] == 2'b00) begin
            unique case (req.request_code)
              RQ_GET_DESCRIPTOR: begin
                if (req.descriptor_found) begin
                  start       = 1'b1;
                  start_total = req.descriptor_length;
                  start_limit = req.request_length;
                end else begin
                  result.packet_action = ACT_STALL;
                end
              end
              RQ_SET_ADDRESS: begin
                pending_address_next = req.request_value[6:0];
                address_pending_next = 1'b1;
                start                = 1'b1;
              end
              RQ_SET_CONFIG: begin
                start          = 1'b1;
                dev_state_next = DS_CONFIGURED;
                ep1_on_next    = 1'b1;
              end
              default: begin
              end
            endcase
          end else if (req.request_code == RQ_GET_INTERFACE) begin
            start       = 1'b1;
            start_src   = SRC_CONST_ONE;
            start_total = 16'd1;
            start_limit = 16'd1;
          end
        end
      end
      EV_IN: begin
        emit = (req.endpoint == 4'd0) && sending;
      end
      EV_ACK: begin
        if (req.endpoint == 4'd0) begin
          emit = sending;
          if (address_pending) begin
            dev_state_next       = DS_ADDRESSED;
            active_address_next  = pending_address;
            address_pending_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (start) begin
      cur_src    = start_src;
      cur_sent   = 16'd0;
      cur_end    = (start_total < start_limit) ? start_total : start_limit;
      cur_toggle = 1'b0;
    end else begin
      cur_src    = source_sel;
      cur_sent   = bytes_sent;
      cur_end    = send_end;
      cur_toggle = data_pid;
    end
    remain = (cur_sent < cur_end) ? (cur_end - cur_sent) : 16'd0;
    count  = (remain < {9'd0, size}) ? remain[6:0] : size;

    if (start || emit) begin
      result.packet_action  = ACT_ARM;
      result.payload_source = cur_src;
      result.payload_offset = cur_sent;
      result.payload_count  = count;
      result.data_toggle    = !cur_toggle;
      source_sel_next       = cur_src;
      send_end_next         = cur_end;
      data_pid_next         = !cur_toggle;
      bytes_sent_next       = cur_sent + {9'd0, count};
      sending_next          = !(count < size);
    end

    result.device_state   = dev_state_next;
    result.device_address = active_address_next;
    result.ep1_in_enabled = ep1_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= CFG_PACKET_RESET;
    end else if (cfg_we) begin
      max_packet_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_state       <= DS_POWERED;
      active_address  <= 7'd0;
      pending_address <= 7'd0;
      address_pending <= 1'b0;
      sending         <= 1'b0;
      bytes_sent      <= 16'd0;
      send_end        <= 16'd0;
      data_pid        <= 1'b0;
      source_sel      <= SRC_DESCRIPTOR;
      ep1_on          <= 1'b0;
    end else if (take) begin
      dev_state       <= dev_state_next;
      active_address  <= active_address_next;
      pending_address <= pending_address_next;
      address_pending <= address_pending_next;
      sending         <= sending_next;
      bytes_sent      <= bytes_sent_next;
      send_end        <= send_end_next;
      data_pid        <= data_pid_next;
      source_sel      <= source_sel_next;
      ep1_on          <= ep1_on_next;
    end
  end

endmodule

`default_nettype wire

### rtl/usb_cee_out_reg.sv
// Result register of the USB control endpoint zero engine.
// Depends on usb_cee_pkg.
`default_nettype none

module usb_cee_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      advance,
  input  wire usb_cee_pkg::result_t in_result,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output usb_cee_pkg::result_t      out_result
);
  import usb_cee_pkg::*;

  logic    valid;
  result_t held;

  assign advance    = in_valid && (!valid || out_ready);
  assign out_valid  = valid;
  assign out_result = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= in_result;
    end
  end

endmodule

`default_nettype wire

### rtl/usb_control_endpoint_engine_unit.sv
// USB device control endpoint zero engine, top level.
// Channels: req (sink) carries one bus event per transfer: bus reset, module
// on, SETUP, IN token, ACK or other pid, with the setup fields and the answer
// of an outside descriptor resolver. res (source) returns exactly one result
// per event: the packet action (none, arm IN data, stall), the chunk offset,
// byte count and data toggle, and the device state, address and EP1 IN enable
// after the event. cfg (sink) writes the endpoint zero packet size, always ready;
// the user must write it only while no event is in flight; it is not enforced.
// Path: an accepted event waits in the input register, and when it advances
// its result is registered in the result register, which raises res.valid.
// Throughput: one event per cycle while res is taken; the state update
// is a single compare, subtract and add path between the two registers.
// Stall: while res is not taken the result register holds, and req.ready drops
// as soon as the input register holds an event.
// Reset: rst is synchronous; the device is powered with address zero, no
// delivery open, EP1 IN disabled and a packet size of 8.
// Depends on usb_cee_pkg, usb_cee_ifs, usb_cee_in_reg, usb_cee_core,
// usb_cee_out_reg.
`default_nettype none

module usb_control_endpoint_engine_unit #(
  parameter int PACKET_BYTES_MAX = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  usb_cee_req_if.sink   req,
  usb_cee_res_if.source res,
  usb_cee_cfg_if.sink   cfg
);
  import usb_cee_pkg::*;

  request_t    in_req;
  staged_req_t staged;
  result_t     step_result;
  result_t     out_result;
  logic        advance;

  assign in_req = '{
    req_type:          req.req_type,
    endpoint:          req.endpoint,
    request_type_bits: req.request_type_bits,
    request_code:      req.request_code,
    request_value:     req.request_value,
    request_length:    req.request_length,
    descriptor_found:  req.descriptor_found,
    descriptor_length: req.descriptor_length
  };

  assign cfg.ready = 1'b1;

  usb_cee_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_req   (in_req),
    .advance  (advance),
    .staged   (staged)
  );

  usb_cee_core #(
    .PACKET_BYTES_MAX (PACKET_BYTES_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.max_packet_bytes),
    .take     (advance),
    .req      (staged.req),
    .result   (step_result)
  );

  usb_cee_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (staged.valid),
    .advance    (advance),
    .in_result  (step_result),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_result (out_result)
  );

  assign res.packet_action  = out_result.packet_action;
  assign res.payload_source = out_result.payload_source;
  assign res.payload_offset = out_result.payload_offset;
  assign res.payload_count  = out_result.payload_count;
  assign res.data_toggle    = out_result.data_toggle;
  assign res.device_state   = out_result.device_state;
  assign res.device_address = out_result.device_address;
  assign res.ep1_in_enabled = out_result.ep1_in_enabled;

endmodule

`default_nettype wire
